// ===== hw/rtl/xlzd_pkg.sv =====
// ----------------------------------------------------------------------------
// xlzd_pkg
// Shared types and constants for the keyed LZSS entry decompressor.
// ----------------------------------------------------------------------------
package xlzd_pkg;

   localparam int WIN_BYTES = 4096;
   localparam int WIN_AW    = $clog2(WIN_BYTES);
   localparam int WIN_CW    = $clog2(WIN_BYTES + 1);

   localparam logic [WIN_AW-1:0] WIN_START = WIN_AW'(12'hfee);

   localparam logic [3:0] HDR_LEN   = 4'd8;
   localparam logic [4:0] MATCH_MIN = 5'd3;
   localparam logic [7:0] KEY_RESET = 8'h72;

   // header characters
   localparam logic [7:0] CHR_THREE = 8'h33;  // '3'
   localparam logic [7:0] CHR_SEMI  = 8'h3b;  // ';'
   localparam logic [7:0] CHR_ONE   = 8'h31;  // '1'
   localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'

   localparam logic [1:0] ST_DATA = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_LZSS,
      MODE_PLAIN,
      MODE_BAD
   } mode_type;

   typedef struct packed {
      logic              rd_en;
      logic [WIN_AW-1:0] rd_addr;
      logic              wr_en;
      logic [7:0]        wr_data;
      logic              clear;
   } win_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  status;
      logic [31:0] produced_count;
      logic        run_last;
   } rsp_item_type;

endpackage

// ===== hw/rtl/xlzd_window.sv =====
// ----------------------------------------------------------------------------
// xlzd_window
// 4 KB history window: one write port at the running write pointer, one
// registered read port, fill count for the per-entry zero state, and
// forwarding of a write that lands on the address being read.
// ----------------------------------------------------------------------------
module xlzd_window (
   input  logic                 clock,
   input  logic                 reset,
   input  xlzd_pkg::win_req_type win_req,
   output logic [7:0]           rd_data
);

   logic [7:0]                  mem [xlzd_pkg::WIN_BYTES];
   logic [7:0]                  mem_q_ff;
   logic [xlzd_pkg::WIN_AW-1:0] wp_ff, wp_in;
   logic [xlzd_pkg::WIN_CW-1:0] fill_ff, fill_in;
   logic                        hit_ff, hit_in;
   logic                        fwd_ff, fwd_in;
   logic [7:0]                  fwd_data_ff;
   logic [xlzd_pkg::WIN_AW-1:0] rd_dist;

   always_ff @(posedge clock) begin
      if (win_req.wr_en) begin
         mem[wp_ff] <= win_req.wr_data;
      end
      if (win_req.rd_en) begin
         mem_q_ff <= mem[win_req.rd_addr];
      end
   end

   // entries written this entry form one run starting at WIN_START
   always_comb begin
      rd_dist = win_req.rd_addr - xlzd_pkg::WIN_START;
      hit_in  = {1'b0, rd_dist} < fill_ff;
      fwd_in  = win_req.wr_en && (wp_ff == win_req.rd_addr);
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (win_req.clear) begin
         wp_in   = xlzd_pkg::WIN_START;
         fill_in = '0;
      end else if (win_req.wr_en) begin
         wp_in = wp_ff + xlzd_pkg::WIN_AW'(1);
         if (fill_ff != xlzd_pkg::WIN_CW'(xlzd_pkg::WIN_BYTES)) begin
            fill_in = fill_ff + xlzd_pkg::WIN_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= win_req.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= xlzd_pkg::WIN_START;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (hit_ff ? mem_q_ff : 8'h00);

endmodule

// ===== hw/rtl/xlzd_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// xlzd_rsp_fifo
// Two-word result queue between the decoder and the rsp channel.
// ----------------------------------------------------------------------------
module xlzd_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  xlzd_pkg::rsp_item_type push_item,
   input  logic                  pop_ready,
   output logic                  head_valid,
   output xlzd_pkg::rsp_item_type head_item,
   output logic [1:0]            count,
   output logic                  pop
);

   xlzd_pkg::rsp_item_type q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [1:0]             pos;

   always_comb begin
      pop   = (cnt_ff != 2'd0) && pop_ready;
      q0_in = q0_ff;
      q1_in = q1_ff;
      if (pop) begin
         q0_in = q1_ff;
      end
      pos = cnt_ff - {1'b0, pop};
      if (push) begin
         if (pos == 2'd0) begin
            q0_in = push_item;
         end else begin
            q1_in = push_item;
         end
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign head_valid = (cnt_ff != 2'd0);
   assign head_item  = q0_ff;
   assign count      = cnt_ff;

endmodule

// ===== hw/rtl/xor_lzss_entry_decompressor.sv =====
// ----------------------------------------------------------------------------
// xor_lzss_entry_decompressor
// Keyed LZSS / plain entry decoder with a 4 KB history window.
// ----------------------------------------------------------------------------
//  channel | dir | sync          | payload
//  req     | in  | tvalid/tready | tdata[7:0] in_byte, tlast last_byte
//  rsp     | out | tvalid/tready | tdata[7:0] out_byte, tdata[39:8] produced_count,
//          |     |               | tuser[1:0] status, tlast run_last
//  csr     | in  | valid/ready   | data[7:0] xor_key
//
//  A match copies its bytes one by one through the window's single read port,
//  and no new word is taken until the last copied byte has returned. A word
//  that ends an entry adds a status word. Window bytes not written in the
//  current entry read as zero by a fill count, so no clearing pass. Reset is
//  synchronous. A stalled rsp side holds the decoder once the two-word result
//  queue fills.
// ----------------------------------------------------------------------------
module xor_lzss_entry_decompressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [39:8] produced_count
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COPY,
      S_STATUS
   } state_type;

   state_type                   state_ff, state_in;
   logic [7:0]                  key_ff, key_in;
   logic [3:0]                  hdr_pos_ff, hdr_pos_in;
   xlzd_pkg::mode_type          mode_ff, mode_in;
   logic [31:0]                 limit_ff, limit_in;
   logic [31:0]                 count_ff, count_in;
   logic [8:0]                  flags_ff, flags_in;
   logic [8:0]                  pend_ff, pend_in;
   logic [xlzd_pkg::WIN_AW-1:0] copy_addr_ff, copy_addr_in;
   logic [4:0]                  copy_left_ff, copy_left_in;
   logic                        entry_last_ff, entry_last_in;
   logic                        inflight_ff, inflight_in;
   logic                        inflight_rl_ff, inflight_rl_in;

   xlzd_pkg::win_req_type       win_req;
   logic [7:0]                  win_rd_data;
   logic                        push;
   xlzd_pkg::rsp_item_type      push_item;
   xlzd_pkg::rsp_item_type      head_item;
   logic [1:0]                  fifo_count;
   logic                        pop;
   logic [2:0]                  occ;
   logic                        space_ok;
   logic                        req_acc;
   logic [7:0]                  kb;
   logic                        below_limit;
   logic                        final_byte;
   logic                        clear_entry;

   xlzd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .win_req (win_req),
      .rd_data (win_rd_data)
   );

   xlzd_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_item  (head_item),
      .count      (fifo_count),
      .pop        (pop)
   );

   // room for one more word, counting the read in flight
   assign occ      = {1'b0, fifo_count} + {2'b00, inflight_ff} - {2'b00, pop};
   assign space_ok = occ < 3'd2;

   assign req_tready  = (state_ff == S_IDLE) && !inflight_ff && space_ok;
   assign req_acc     = req_tvalid && req_tready;
   assign kb          = req_tdata ^ key_ff;
   assign below_limit = count_ff < limit_ff;
   assign final_byte  = (copy_left_ff == 5'd1) || ((limit_ff - count_ff) == 32'd1);
   assign csr_ready   = 1'b1;

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      hdr_pos_in     = hdr_pos_ff;
      mode_in        = mode_ff;
      limit_in       = limit_ff;
      count_in       = count_ff;
      flags_in       = flags_ff;
      pend_in        = pend_ff;
      copy_addr_in   = copy_addr_ff;
      copy_left_in   = copy_left_ff;
      entry_last_in  = entry_last_ff;
      inflight_in    = 1'b0;
      inflight_rl_in = inflight_rl_ff;
      clear_entry    = 1'b0;
      win_req        = '0;
      win_req.rd_addr = copy_addr_ff;
      win_req.wr_data = kb;
      push           = 1'b0;
      push_item      = '0;

      if (csr_valid) begin
         key_in = csr_data;
      end

      // copied byte returns from the window: store it back and emit it
      if (inflight_ff) begin
         win_req.wr_en       = 1'b1;
         win_req.wr_data     = win_rd_data;
         push                = 1'b1;
         push_item.out_byte  = win_rd_data;
         push_item.status    = xlzd_pkg::ST_DATA;
         push_item.run_last  = inflight_rl_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tlast) begin
                  state_in = S_STATUS;
               end
               if (hdr_pos_ff < xlzd_pkg::HDR_LEN) begin
                  priority if (hdr_pos_ff == 4'd1 && req_tdata != xlzd_pkg::CHR_THREE) begin
                     mode_in = xlzd_pkg::MODE_BAD;
                  end else if (hdr_pos_ff == 4'd2 && req_tdata != xlzd_pkg::CHR_SEMI) begin
                     mode_in = xlzd_pkg::MODE_BAD;
                  end else if (hdr_pos_ff == 4'd3 && mode_ff != xlzd_pkg::MODE_BAD) begin
                     if (req_tdata == xlzd_pkg::CHR_ONE) begin
                        mode_in = xlzd_pkg::MODE_LZSS;
                     end else if (req_tdata == xlzd_pkg::CHR_ZERO) begin
                        mode_in = xlzd_pkg::MODE_PLAIN;
                     end else begin
                        mode_in = xlzd_pkg::MODE_BAD;
                     end
                  end else if (hdr_pos_ff >= 4'd4) begin
                     limit_in[{hdr_pos_ff[1:0], 3'b000} +: 8] = req_tdata;
                  end else begin
                     mode_in = mode_ff;
                  end
                  hdr_pos_in = hdr_pos_ff + 4'd1;
               end else if (mode_ff == xlzd_pkg::MODE_LZSS) begin
                  if (pend_ff[8]) begin
                     copy_addr_in  = {kb[7:4], pend_ff[7:0]};
                     copy_left_in  = 5'(kb[3:0]) + xlzd_pkg::MATCH_MIN;
                     entry_last_in = req_tlast;
                     pend_in       = '0;
                     state_in      = S_COPY;
                  end else if (flags_ff <= 9'd1) begin
                     flags_in = {1'b1, kb};
                  end else begin
                     flags_in = {1'b0, flags_ff[8:1]};
                     if (flags_ff[0]) begin
                        if (below_limit) begin
                           push               = 1'b1;
                           push_item.out_byte = kb;
                           push_item.status   = xlzd_pkg::ST_DATA;
                           push_item.run_last = !req_tlast;
                           count_in           = count_ff + 32'd1;
                           win_req.wr_en      = 1'b1;
                        end
                     end else begin
                        pend_in = {1'b1, kb};
                     end
                  end
               end else if (mode_ff == xlzd_pkg::MODE_PLAIN) begin
                  if (below_limit) begin
                     push               = 1'b1;
                     push_item.out_byte = kb;
                     push_item.status   = xlzd_pkg::ST_DATA;
                     push_item.run_last = !req_tlast;
                     count_in           = count_ff + 32'd1;
                  end
               end
            end
         end

         S_COPY: begin
            if (!below_limit) begin
               state_in = entry_last_ff ? S_STATUS : S_IDLE;
            end else if (space_ok) begin
               win_req.rd_en  = 1'b1;
               count_in       = count_ff + 32'd1;
               copy_addr_in   = copy_addr_ff + xlzd_pkg::WIN_AW'(1);
               copy_left_in   = copy_left_ff - 5'd1;
               inflight_in    = 1'b1;
               inflight_rl_in = final_byte && !entry_last_ff;
               if (final_byte) begin
                  state_in = entry_last_ff ? S_STATUS : S_IDLE;
               end
            end
         end

         S_STATUS: begin
            if (!inflight_ff && space_ok) begin
               push               = 1'b1;
               push_item.out_byte = 8'h00;
               push_item.run_last = 1'b1;
               if (hdr_pos_ff < xlzd_pkg::HDR_LEN || mode_ff == xlzd_pkg::MODE_BAD ||
                   mode_ff == xlzd_pkg::MODE_NONE) begin
                  push_item.status         = xlzd_pkg::ST_BAD;
                  push_item.produced_count = 32'd0;
               end else begin
                  push_item.status         = xlzd_pkg::ST_OK;
                  push_item.produced_count = count_ff;
               end
               clear_entry = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (clear_entry) begin
         hdr_pos_in = '0;
         mode_in    = xlzd_pkg::MODE_NONE;
         limit_in   = '0;
         count_in   = '0;
         flags_in   = '0;
         pend_in    = '0;
      end
      win_req.clear = clear_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         key_ff         <= xlzd_pkg::KEY_RESET;
         hdr_pos_ff     <= '0;
         mode_ff        <= xlzd_pkg::MODE_NONE;
         limit_ff       <= '0;
         count_ff       <= '0;
         flags_ff       <= '0;
         pend_ff        <= '0;
         copy_addr_ff   <= '0;
         copy_left_ff   <= '0;
         entry_last_ff  <= 1'b0;
         inflight_ff    <= 1'b0;
         inflight_rl_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         key_ff         <= key_in;
         hdr_pos_ff     <= hdr_pos_in;
         mode_ff        <= mode_in;
         limit_ff       <= limit_in;
         count_ff       <= count_in;
         flags_ff       <= flags_in;
         pend_ff        <= pend_in;
         copy_addr_ff   <= copy_addr_in;
         copy_left_ff   <= copy_left_in;
         entry_last_ff  <= entry_last_in;
         inflight_ff    <= inflight_in;
         inflight_rl_ff <= inflight_rl_in;
      end
   end

   assign rsp_tdata = {head_item.produced_count, head_item.out_byte};
   assign rsp_tuser = head_item.status;
   assign rsp_tlast = head_item.run_last;

endmodule

// ===== tb/sv/xor_lzss_entry_decompressor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_lzss_entry_decompressor_tb
// Self-checking bench for the keyed LZSS / plain entry decoder. A short
// table of hand-built entries runs first, then random entries under several
// xor keys. A cycle-free model of the decoder predicts each output word not
// given by hand in the table, and each word is compared field by field as it
// leaves the block. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module xor_lzss_entry_decompressor_tb;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;    // expected word below is given by hand
      logic [1:0]  status;
      logic [31:0] count;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [7:0] out_byte, [39:8] produced_count
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   xor_lzss_entry_decompressor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // decoder model state
   logic [7:0]  key;
   logic [7:0]  hist [0:xlzd_pkg::WIN_BYTES-1];
   logic [11:0] wr_ptr;
   logic [8:0]  flag_sr;
   logic [8:0]  match_lo;
   int          hdr_pos;
   xlzd_pkg::mode_type mode;
   logic [31:0] out_limit;
   logic [31:0] out_count;

   xlzd_pkg::rsp_item_type step_words[$];
   xlzd_pkg::rsp_item_type expected_words[$];
   logic [7:0]             entry_raw[$];

   int errors;
   int words_checked;
   int status_words;
   int items_sent;
   int entries_sent;
   int idle_level;

   dir_row_type directed_rows [34] = '{
      // short entry, second header byte wrong
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_SEMI,  1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_ONE,   1'b1, 1'b1, xlzd_pkg::ST_BAD,  32'd0},
      // header only, LZSS, zero limit
      '{8'hff,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_THREE, 1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_SEMI,  1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_ONE,   1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b1, 1'b1, xlzd_pkg::ST_OK,   32'd0},
      // LZSS, limit 3: literal, overlapping match cut by the limit, dangling match
      '{8'h4c,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_THREE, 1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_SEMI,  1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_ONE,   1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h03,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h73,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'hff,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h9c,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h82,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h00,               1'b1, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      // plain copy, all-ones limit
      '{8'h00,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_THREE, 1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_SEMI,  1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{xlzd_pkg::CHR_ZERO,  1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'hff,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'hff,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'hff,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'hff,               1'b0, 1'b0, xlzd_pkg::ST_DATA, 32'd0},
      '{8'h72,               1'b1, 1'b0, xlzd_pkg::ST_DATA, 32'd0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (idle_level == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void clear_entry_state();
      for (int i = 0; i < xlzd_pkg::WIN_BYTES; i++) hist[i] = 8'h00;
      wr_ptr    = xlzd_pkg::WIN_START;
      flag_sr   = '0;
      match_lo  = '0;
      hdr_pos   = 0;
      mode      = xlzd_pkg::MODE_NONE;
      out_limit = '0;
      out_count = '0;
   endfunction

   // nothing leaves once the limit is reached, and the window is left alone
   function automatic void emit_byte(input logic [7:0] b, input bit to_win);
      xlzd_pkg::rsp_item_type w;
      if (out_count >= out_limit) return;
      w          = '0;
      w.out_byte = b;
      w.status   = xlzd_pkg::ST_DATA;
      step_words.push_back(w);
      if (to_win) begin
         hist[wr_ptr] = b;
         wr_ptr       = wr_ptr + 12'd1;
      end
      out_count = out_count + 32'd1;
   endfunction

   function automatic void lzss_byte(input logic [7:0] b);
      logic [11:0] base;
      logic [11:0] rd;
      int          len;
      if (match_lo[8]) begin
         base     = {b[7:4], match_lo[7:0]};
         len      = int'(b[3:0]) + int'(xlzd_pkg::MATCH_MIN);
         match_lo = '0;
         for (int i = 0; i < len; i++) begin
            rd = base + 12'(i);
            emit_byte(hist[rd], 1'b1);
         end
      end else if (flag_sr <= 9'd1) begin
         flag_sr = {1'b1, b};
      end else if (flag_sr[0]) begin
         flag_sr = flag_sr >> 1;
         emit_byte(b, 1'b1);
      end else begin
         flag_sr  = flag_sr >> 1;
         match_lo = {1'b1, b};
      end
   endfunction

   // words caused by one input word land in step_words
   function automatic void predict_word(input logic [7:0] raw, input logic last);
      logic [7:0]             b;
      xlzd_pkg::rsp_item_type w;
      step_words.delete();
      if (hdr_pos < int'(xlzd_pkg::HDR_LEN)) begin
         if (hdr_pos == 1 && raw != xlzd_pkg::CHR_THREE)
            mode = xlzd_pkg::MODE_BAD;
         else if (hdr_pos == 2 && raw != xlzd_pkg::CHR_SEMI)
            mode = xlzd_pkg::MODE_BAD;
         else if (hdr_pos == 3 && mode != xlzd_pkg::MODE_BAD) begin
            if (raw == xlzd_pkg::CHR_ONE)       mode = xlzd_pkg::MODE_LZSS;
            else if (raw == xlzd_pkg::CHR_ZERO) mode = xlzd_pkg::MODE_PLAIN;
            else                                mode = xlzd_pkg::MODE_BAD;
         end else if (hdr_pos >= 4)
            out_limit = out_limit | (32'(raw) << (8 * (hdr_pos - 4)));
         hdr_pos++;
      end else begin
         b = raw ^ key;
         if (mode == xlzd_pkg::MODE_LZSS)       lzss_byte(b);
         else if (mode == xlzd_pkg::MODE_PLAIN) emit_byte(b, 1'b0);
      end
      if (last) begin
         w = '0;
         if (hdr_pos < int'(xlzd_pkg::HDR_LEN) || mode == xlzd_pkg::MODE_BAD ||
             mode == xlzd_pkg::MODE_NONE) begin
            w.status = xlzd_pkg::ST_BAD;
         end else begin
            w.status         = xlzd_pkg::ST_OK;
            w.produced_count = out_count;
         end
         step_words.push_back(w);
         clear_entry_state();
      end
      if (step_words.size() > 0) begin
         w          = step_words.pop_back();
         w.run_last = 1'b1;
         step_words.push_back(w);
      end
   endfunction

   // header plus payload; mostly well-formed, some short or bad headers,
   // some cut off inside the payload
   function automatic void build_random_entry();
      int          r;
      int          n;
      int          cut;
      bit          lzss;
      logic [7:0]  flags;
      logic [11:0] off;
      logic [31:0] lim;
      entry_raw.delete();
      lzss = $urandom_range(0, 99) < 60;
      r    = $urandom_range(0, 99);
      if (r < 10)      lim = 32'd0;
      else if (r < 20) lim = '1;
      else if (r < 28) lim = $urandom;
      else             lim = $urandom_range(0, 48);
      entry_raw.push_back(8'($urandom));
      entry_raw.push_back(xlzd_pkg::CHR_THREE);
      entry_raw.push_back(xlzd_pkg::CHR_SEMI);
      entry_raw.push_back(lzss ? xlzd_pkg::CHR_ONE : xlzd_pkg::CHR_ZERO);
      for (int i = 0; i < 4; i++) entry_raw.push_back(lim[8*i +: 8]);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         n = $urandom_range(1, 7);
         while (entry_raw.size() > n) void'(entry_raw.pop_back());
         return;
      end
      if (r < 18) entry_raw[$urandom_range(1, 3)] = 8'($urandom);
      if (lzss) begin
         n = $urandom_range(0, 3);
         for (int g = 0; g < n; g++) begin
            flags = 8'($urandom);
            entry_raw.push_back(flags ^ key);
            for (int k = 0; k < 8; k++) begin
               if (flags[k]) begin
                  entry_raw.push_back(8'($urandom));
               end else begin
                  // aim most matches at bytes written by this entry
                  if ($urandom_range(0, 99) < 70) begin
                     off = xlzd_pkg::WIN_START + 12'($urandom_range(0, 40));
                  end else begin
                     off = 12'($urandom);
                  end
                  entry_raw.push_back(off[7:0] ^ key);
                  entry_raw.push_back({off[11:8], 4'($urandom)} ^ key);
               end
            end
         end
      end else begin
         n = $urandom_range(0, 24);
         for (int i = 0; i < n; i++) entry_raw.push_back(8'($urandom));
      end
      if (entry_raw.size() > 8 && $urandom_range(0, 5) == 0) begin
         cut = $urandom_range(1, 3);
         while (cut > 0 && entry_raw.size() > 8) begin
            void'(entry_raw.pop_back());
            cut--;
         end
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last,
                            input bit use_typed,
                            input xlzd_pkg::rsp_item_type typed_word);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_word(b, last);
      if (use_typed) expected_words.push_back(typed_word);
      else foreach (step_words[i]) expected_words.push_back(step_words[i]);
      items_sent++;
      if (last) entries_sent++;
   endtask

   // a match may still be copying when its last word is seen, so pad a bit
   task automatic drain_all();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_key(input logic [7:0] k);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= k;
      do @(posedge clock); while (!csr_ready);
      key = k;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : rsp_side
      int hold;
      rsp_tready = 1'b0;
      forever begin
         hold = pick_gap();
         repeat (hold) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         hold = $urandom_range(1, 12);
         repeat (hold) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      xlzd_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            errors++;
            $error("unexpected output word: tdata=%h tuser=%0d tlast=%0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (want.status != xlzd_pkg::ST_DATA) status_words++;
            if (rsp_tdata[7:0] !== want.out_byte) begin
               errors++;
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_tdata[7:0]);
            end
            if (rsp_tuser !== want.status) begin
               errors++;
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
            end
            if (rsp_tdata[39:8] !== want.produced_count) begin
               errors++;
               $error("produced_count: expected %0d, got %0d",
                      want.produced_count, rsp_tdata[39:8]);
            end
            if (rsp_tlast !== want.run_last) begin
               errors++;
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_tlast);
            end
         end
      end
   end

   initial begin
      xlzd_pkg::rsp_item_type typed;
      logic [7:0]             new_key;
      int                     phase_items;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      errors        = 0;
      words_checked = 0;
      status_words  = 0;
      items_sent    = 0;
      entries_sent  = 0;
      idle_level    = 1;
      key           = xlzd_pkg::KEY_RESET;
      clear_entry_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hand-built entries, under the key's reset value
      foreach (directed_rows[i]) begin
         typed                = '0;
         typed.status         = directed_rows[i].status;
         typed.produced_count = directed_rows[i].count;
         typed.run_last       = 1'b1;
         send_byte(directed_rows[i].data, directed_rows[i].last,
                   directed_rows[i].typed, typed);
      end
      drain_all();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       new_key = 8'h00;
            1:       new_key = 8'hff;
            default: new_key = 8'($urandom);
         endcase
         idle_level = (p == 2) ? 0 : 1;
         write_key(new_key);
         phase_items = 0;
         while (phase_items < 45) begin
            build_random_entry();
            foreach (entry_raw[i])
               send_byte(entry_raw[i], i == entry_raw.size() - 1, 1'b0, '0);
            phase_items += entry_raw.size();
         end
         drain_all();
      end

      $display("sent %0d input words in %0d entries under 6 xor key settings",
               items_sent, entries_sent);
      $display("checked %0d output words, %0d of them entry status",
               words_checked, status_words);
      if (errors == 0) begin
         $display("xor_lzss_entry_decompressor verification clean");
      end else begin
         $display("xor_lzss_entry_decompressor verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("xor_lzss_entry_decompressor verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/xlzd_pkg.sv
hw/rtl/xlzd_window.sv
hw/rtl/xlzd_rsp_fifo.sv
hw/rtl/xor_lzss_entry_decompressor.sv
tb/sv/xor_lzss_entry_decompressor_tb.sv
